// ===== hw/rtl/escape_sequence_checker_defines.svh =====
// ----------------------------------------------------------------------------
// Escape sequence checker assertion macros
// Shared assertion wrappers for the escape sequence checker RTL.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_SEQUENCE_CHECKER_DEFINES_SVH
`define ESCAPE_SEQUENCE_CHECKER_DEFINES_SVH

// Checked only while the block is out of reset.
`define ESC_CHK_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define ESC_CHK_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/esc_chk_pkg.sv =====
// ----------------------------------------------------------------------------
// Escape sequence checker package
// Status codes, numeric limits and the digit decoder of the checker.
// ----------------------------------------------------------------------------
package esc_chk_pkg;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_UNKNOWN_ESCAPE = 3'd1,
        ST_NOT_TERMINATED = 3'd2,
        ST_ILLEGAL_DIGIT  = 3'd3,
        ST_BAD_CODE_POINT = 3'd4
    } t_status;

    localparam int unsigned ACC_W  = 32;
    localparam int unsigned LEFT_W = 4;

    localparam logic [ACC_W-1:0] MAX_CODE_POINT = 32'h0010_FFFF;
    localparam logic [ACC_W-1:0] SURR_LOW       = 32'h0000_D800;
    localparam logic [ACC_W-1:0] SURR_END       = 32'h0000_E000;
    localparam logic [ACC_W-1:0] BYTE_LIMIT     = 32'h0000_00FF;

    localparam logic [LEFT_W-1:0] OCT_MORE   = 4'd2;
    localparam logic [LEFT_W-1:0] HEX2_COUNT = 4'd2;
    localparam logic [LEFT_W-1:0] HEX4_COUNT = 4'd4;
    localparam logic [LEFT_W-1:0] HEX8_COUNT = 4'd8;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_digit;

    // Decodes one byte as a hex digit, either letter case.
    function automatic t_digit decode_digit(input logic [7:0] ch);
        logic [7:0] low;
        t_digit     d;
        low     = ch | 8'h20;
        d.valid = 1'b0;
        d.value = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            d.valid = 1'b1;
            d.value = ch[3:0];
        end else if (low >= 8'h61 && low <= 8'h66) begin
            d.valid = 1'b1;
            d.value = 4'(low - 8'h57);
        end
        return d;
    endfunction

endpackage

// ===== hw/rtl/escape_sequence_checker.sv =====
// ----------------------------------------------------------------------------
// Escape sequence checker
// Validates one escape sequence of a string or rune literal, one character
// per item, from the character after the backslash to the end of the run.
//
//   channel | valid   | stall   | fields
//   --------+---------+---------+------------------------------------------
//   in      | i_valid | o_stall | i_char_code, i_first_after_backslash,
//           |         |         | i_quote_char
//   out     | o_valid | i_stall | o_consumed, o_done_res, o_status
//
// One item per cycle while the result is not held; each item is registered in
// the input register and its result then in the result register.
// The digit-run state is updated in the same cycle as the result register.
// Reset is synchronous and active low and clears the run state.
// A held result stalls the input register, which raises o_stall while it holds an item.
// ----------------------------------------------------------------------------
`include "escape_sequence_checker_defines.svh"

module escape_sequence_checker
    import esc_chk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic signed [8:0] i_char_code,
    input  logic              i_first_after_backslash,
    input  logic        [7:0] i_quote_char,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_consumed,
    output logic              o_done_res,
    output logic        [2:0] o_status
);

    logic              r_in_valid;
    logic signed [8:0] r_in_char;
    logic              r_in_first;
    logic        [7:0] r_in_quote;

    logic              r_in_digits;
    logic [LEFT_W-1:0] r_digits_left;
    logic              r_radix_is_hex;
    logic              r_limit_is_byte;
    logic [ACC_W-1:0]  r_acc;

    logic              n_in_digits;
    logic [LEFT_W-1:0] n_digits_left;
    logic              n_radix_is_hex;
    logic              n_limit_is_byte;
    logic [ACC_W-1:0]  n_acc;

    logic              r_out_valid;
    logic              r_out_consumed;
    logic              r_out_done;
    t_status           r_out_status;

    logic              n_consumed;
    logic              n_done;
    t_status           n_status;

    logic              advance;
    logic              take_in;
    logic              is_eoi;
    logic        [7:0] ch;
    t_digit            dig;
    logic              dig_ok;
    logic [ACC_W-1:0]  acc_shift;
    logic [LEFT_W-1:0] left_dec;
    logic              over_limit;

    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;
    assign take_in = i_valid && !o_stall;

    assign is_eoi    = r_in_char[8];
    assign ch        = r_in_char[7:0];
    assign dig       = decode_digit(ch);
    assign dig_ok    = !is_eoi && dig.valid && (r_radix_is_hex || !dig.value[3]);
    assign acc_shift = r_radix_is_hex ? {r_acc[ACC_W-5:0], dig.value}
                                      : {r_acc[ACC_W-4:0], dig.value[2:0]};
    assign left_dec  = r_digits_left - LEFT_W'(1);
    assign over_limit = r_limit_is_byte
                      ? (acc_shift > BYTE_LIMIT)
                      : (acc_shift > MAX_CODE_POINT
                         || (acc_shift >= SURR_LOW && acc_shift < SURR_END));

    always_comb begin
        n_in_digits     = r_in_digits;
        n_digits_left   = r_digits_left;
        n_radix_is_hex  = r_radix_is_hex;
        n_limit_is_byte = r_limit_is_byte;
        n_acc           = r_acc;
        n_consumed      = 1'b0;
        n_done          = 1'b0;
        n_status        = ST_OK;
        if (r_in_first) begin
            // A new backslash always abandons a run in progress.
            n_in_digits   = 1'b0;
            n_digits_left = '0;
            if (!is_eoi && ch == r_in_quote) begin
                n_consumed = 1'b1;
                n_done     = 1'b1;
            end else if (is_eoi) begin
                n_done   = 1'b1;
                n_status = ST_NOT_TERMINATED;
            end else begin
                unique case (ch) inside
                    8'h61, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74, 8'h76, 8'h5C: begin
                        n_consumed = 1'b1;
                        n_done     = 1'b1;
                    end
                    [8'h30:8'h37]: begin
                        n_consumed      = 1'b1;
                        n_in_digits     = 1'b1;
                        n_digits_left   = OCT_MORE;
                        n_radix_is_hex  = 1'b0;
                        n_limit_is_byte = 1'b1;
                        n_acc           = {{(ACC_W-3){1'b0}}, ch[2:0]};
                    end
                    8'h78: begin
                        n_consumed      = 1'b1;
                        n_in_digits     = 1'b1;
                        n_digits_left   = HEX2_COUNT;
                        n_radix_is_hex  = 1'b1;
                        n_limit_is_byte = 1'b1;
                        n_acc           = '0;
                    end
                    8'h75: begin
                        n_consumed      = 1'b1;
                        n_in_digits     = 1'b1;
                        n_digits_left   = HEX4_COUNT;
                        n_radix_is_hex  = 1'b1;
                        n_limit_is_byte = 1'b0;
                        n_acc           = '0;
                    end
                    8'h55: begin
                        n_consumed      = 1'b1;
                        n_in_digits     = 1'b1;
                        n_digits_left   = HEX8_COUNT;
                        n_radix_is_hex  = 1'b1;
                        n_limit_is_byte = 1'b0;
                        n_acc           = '0;
                    end
                    default: begin
                        n_done   = 1'b1;
                        n_status = ST_UNKNOWN_ESCAPE;
                    end
                endcase
            end
        end else if (r_in_digits) begin
            if (!dig_ok) begin
                n_done        = 1'b1;
                n_status      = is_eoi ? ST_NOT_TERMINATED : ST_ILLEGAL_DIGIT;
                n_in_digits   = 1'b0;
                n_digits_left = '0;
            end else begin
                n_consumed    = 1'b1;
                n_acc         = acc_shift;
                n_digits_left = left_dec;
                if (left_dec == '0) begin
                    n_done      = 1'b1;
                    n_in_digits = 1'b0;
                    if (over_limit) begin
                        n_status = ST_BAD_CODE_POINT;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance || !r_in_valid) begin
            r_in_valid <= take_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_char  <= i_char_code;
            r_in_first <= i_first_after_backslash;
            r_in_quote <= i_quote_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_digits     <= 1'b0;
            r_digits_left   <= '0;
            r_radix_is_hex  <= 1'b0;
            r_limit_is_byte <= 1'b0;
            r_acc           <= '0;
            r_out_valid     <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_in_digits     <= n_in_digits;
                r_digits_left   <= n_digits_left;
                r_radix_is_hex  <= n_radix_is_hex;
                r_limit_is_byte <= n_limit_is_byte;
                r_acc           <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_consumed <= n_consumed;
            r_out_done     <= n_done;
            r_out_status   <= n_status;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_consumed = r_out_consumed;
    assign o_done_res = r_out_done;
    assign o_status   = r_out_status;

    // The shown result always matches the run state it left behind.
    `ESC_CHK_ASSERT(a_fail_ends_seq, o_valid && o_status != ST_OK |-> o_done_res, "error status without end of sequence")
    `ESC_CHK_ASSERT(a_open_run, o_valid && o_consumed && !o_done_res |-> r_in_digits, "open sequence without digit run")
    `ESC_CHK_ASSERT(a_done_closes, o_valid && o_done_res |-> !r_in_digits, "digit run survives end of sequence")
    `ESC_CHK_ASSERT(a_run_count, r_in_digits |-> r_digits_left != '0, "digit run with no digits left")
    `ESC_CHK_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_valid && !r_in_valid, "reset left an item in flight")

endmodule
